// File: src/uigf_pkg.sv
// Shared constants for the UART idle-gap framer.
package uigf_pkg;

  // Default store depth in bytes.
  localparam int BUFFER_BYTES_DEF = 64;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int TICK_W = 8;

  // Input opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration port layout.
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_IDLE_TICKS = 1'b0;  // word select bit paddr[2]
  localparam logic [TICK_W-1:0] IDLE_TICKS_RESET = 8'd5;

endpackage

// File: src/uigf_ram.sv
// Generic simple dual-port RAM with registered read data.
module uigf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: src/uart_idle_gap_framer_top.sv
// Top level of the UART idle-gap framer: control, store and frame emission.
//
// The block cuts a received UART byte stream into frames at idle gaps.
// Input words arrive on the in_ channel: opcode 0 carries a received byte,
// opcode 1 is a periodic tick. A byte word is written into the store when
// there is room and is otherwise dropped; either way the idle counter is
// cleared. A tick word compares the stored count with the count seen at
// the previous tick. Once the count has stayed unchanged and nonzero for
// idle_ticks_to_close ticks, the next tick closes the frame.
// Byte words and ticks that do not close a frame leave the input side open,
// so the block accepts a word every cycle between frames. A closing tick
// starts the emission sequencer, which walks the store through its one read
// port: each frame byte is read, then loaded into the output register, and
// in_stall stays high until the last byte of the frame has been loaded.
// Result words leave through an output register on the out_ channel. While
// out_stall is high the register holds its word and the sequencer waits.
// Reset clears the counts, the idle counter and the output valid, and sets
// idle_ticks_to_close to 5. The store itself is not cleared: a frame only
// reads entries written since the previous frame.
module uart_idle_gap_framer_top #(
  parameter int BUFFER_BYTES = uigf_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [uigf_pkg::BYTE_W-1:0]      in_rx_byte,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [uigf_pkg::BYTE_W-1:0]      out_frame_byte,
  output logic [uigf_pkg::IDX_W-1:0]       out_byte_index,
  output logic [uigf_pkg::CNT_W-1:0]       out_frame_length,
  output logic                             out_last_in_frame,
  // Configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [uigf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [uigf_pkg::CNT_W-1:0] BUF_CNT = uigf_pkg::CNT_W'(BUFFER_BYTES);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [uigf_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [uigf_pkg::CNT_W-1:0]    last_tick_cnt_r, last_tick_cnt_nxt;
  logic [uigf_pkg::TICK_W-1:0]   idle_cnt_r, idle_cnt_nxt;
  logic [uigf_pkg::TICK_W-1:0]   idle_ticks_r;
  logic [uigf_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [uigf_pkg::CNT_W-1:0]    len_r, len_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [uigf_pkg::BYTE_W-1:0]   out_byte_r;
  logic [uigf_pkg::IDX_W-1:0]    out_idx_r;
  logic [uigf_pkg::CNT_W-1:0]    out_len_r;
  logic                          out_last_r;

  logic                          in_acc;
  logic                          cfg_wr;
  logic                          store_we;
  logic                          rd_en;
  logic                          close_frame;
  logic                          out_load;
  logic                          idx_is_last;
  logic [uigf_pkg::BYTE_W-1:0]   rd_data;

  // Configuration register. It is meant to be written only while the
  // block is idle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r <= uigf_pkg::IDLE_TICKS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == uigf_pkg::REG_IDLE_TICKS)) begin
      idle_ticks_r <= cfg_pwdata[uigf_pkg::TICK_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == uigf_pkg::REG_IDLE_TICKS) ?
                      32'(idle_ticks_r) : 32'd0;

  // The input side is open whenever the sequencer is not walking a frame.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // A byte is stored only while the store has room.
  assign store_we = in_acc && (in_opcode == uigf_pkg::OP_BYTE) && (count_r < BUF_CNT);

  // A tick closes the frame once the count has been stable long enough.
  assign close_frame = in_acc && (in_opcode == uigf_pkg::OP_TICK) &&
                       (count_r != '0) && (count_r == last_tick_cnt_r) &&
                       (idle_cnt_r >= idle_ticks_r);

  assign rd_en       = (state_r == S_RD);
  assign idx_is_last = ((uigf_pkg::CNT_W'(idx_r) + 7'd1) == len_r);
  assign out_load    = (state_r == S_LOAD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    last_tick_cnt_nxt = last_tick_cnt_r;
    idle_cnt_nxt      = idle_cnt_r;
    idx_nxt           = idx_r;
    len_nxt           = len_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == uigf_pkg::OP_BYTE) begin
            if (store_we) begin
              count_nxt = count_r + 7'd1;
            end
            idle_cnt_nxt = '0;
          end else if ((count_r != '0) && (count_r == last_tick_cnt_r)) begin
            if (close_frame) begin
              len_nxt      = count_r;
              idx_nxt      = '0;
              count_nxt    = '0;
              idle_cnt_nxt = '0;
              state_nxt    = S_RD;
            end else begin
              idle_cnt_nxt = idle_cnt_r + 8'd1;
            end
          end else begin
            idle_cnt_nxt      = '0;
            last_tick_cnt_nxt = count_r;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_load) begin
          if (idx_is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 6'd1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      count_r         <= '0;
      last_tick_cnt_r <= '0;
      idle_cnt_r      <= '0;
      idx_r           <= '0;
      len_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      count_r         <= count_nxt;
      last_tick_cnt_r <= last_tick_cnt_nxt;
      idle_cnt_r      <= idle_cnt_nxt;
      idx_r           <= idx_nxt;
      len_r           <= len_nxt;
    end
  end

  // Byte store.
  uigf_ram #(
    .WIDTH (uigf_pkg::BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Output register. It holds its word while the receiver stalls.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= rd_data;
      out_idx_r  <= idx_r;
      out_len_r  <= len_r;
      out_last_r <= idx_is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_byte_index    = out_idx_r;
  assign out_frame_length  = out_len_r;
  assign out_last_in_frame = out_last_r;

  // The stored count never runs past the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= BUF_CNT)
    else $error("stored count exceeds store depth");

  // A closing tick starts the emission and closes the input side.
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    close_frame |=> (in_stall && (state_r == S_RD) && (count_r == '0)))
    else $error("closing tick did not start emission");

  // The marked word is the one at the end of its frame.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_in_frame) |->
      ((uigf_pkg::CNT_W'(out_byte_index) + 7'd1) == out_frame_length))
    else $error("last marker at wrong position");

  // Emission only walks a nonempty frame within the store.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((len_r != '0) && (len_r <= BUF_CNT) &&
                             (uigf_pkg::CNT_W'(idx_r) < len_r)))
    else $error("emission index out of frame");

endmodule
